// ===== rtl/ncr_pkg.sv =====
`default_nettype none

package ncr_pkg;

  // Configuration register indices.
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNELS   = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_SRC_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_DST_WIDTH  = 3'd4,
    CFG_MODE       = 3'd5
  } cfg_idx_t;

  // Field widths.
  localparam int ChanRegW = 9;
  localparam int DimRegW  = 11;
  localparam int ModeW    = 2;
  localparam int CfgDataW = 11;
  localparam int BatchW   = 8;
  localparam int ChanW    = 8;
  localparam int PosW     = 10;
  localparam int IndexW   = 32;

  // Interpolation modes.
  localparam logic [ModeW-1:0] MODE_NEAREST = 2'd2;

  // Register values after reset.
  localparam logic [ChanRegW-1:0] RST_CHANNELS   = 9'd3;
  localparam logic [DimRegW-1:0]  RST_SRC_HEIGHT = 11'd256;
  localparam logic [DimRegW-1:0]  RST_SRC_WIDTH  = 11'd256;
  localparam logic [DimRegW-1:0]  RST_DST_HEIGHT = 11'd224;
  localparam logic [DimRegW-1:0]  RST_DST_WIDTH  = 11'd224;
  localparam logic [ModeW-1:0]    RST_MODE       = 2'd2;

  // Internal datapath widths.
  localparam int DivNumW = 20;  // position times (crop size + 1) stays below 2^20
  localparam int PlaneW  = 17;  // batch * channels + channel
  localparam int RowAccW = 28;  // plane * height (+ row)
  localparam int SrcAccW = 29;  // plane * src_height + source row

  typedef struct packed {
    logic [BatchW-1:0] batch;
    logic [ChanW-1:0]  channel;
    logic [PosW-1:0]   out_row;
    logic [PosW-1:0]   out_col;
  } in_item_t;

endpackage

`default_nettype wire

// ===== rtl/nearest_crop_resize_address_gen_unit.sv =====
`default_nettype none

// Throughput: one beat per cycle while out_ready does not stall the output; the
// 20-stage pipelined divider for the row and column scaling sets the depth, and
// every stage advances together.
// Reset: configuration registers return to their defaults, the input buffer and all
// pipeline valid bits clear; datapath registers are not reset.
module nearest_crop_resize_address_gen_unit
  import ncr_pkg::*;
#(
  parameter int MAX_DIM      = 1024,
  parameter int MAX_CHANNELS = 256,
  parameter int MAX_BATCH    = 256,
  parameter int INDEX_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BatchW-1:0]   batch,
  input  logic [ChanW-1:0]    channel,
  input  logic [PosW-1:0]     out_row,
  input  logic [PosW-1:0]     out_col,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [IndexW-1:0]   src_index,
  output logic [IndexW-1:0]   dst_index,
  output logic                mode_ok
);

  // Index wrap: results are taken modulo 2^INDEX_WIDTH, then cut to the 32-bit ports.
  localparam int IdxKeep = (INDEX_WIDTH < IndexW) ? INDEX_WIDTH : IndexW;
  localparam logic [IndexW-1:0] IdxMask =
    (IdxKeep >= IndexW) ? {IndexW{1'b1}} : ((IndexW'(1) << IdxKeep) - IndexW'(1));

  // Range limits, widened so the comparisons see the whole parameter range.
  localparam logic [13:0] MaxDimL   = 14'(MAX_DIM);
  localparam logic [12:0] MaxChanL  = 13'(MAX_CHANNELS);
  localparam logic [16:0] MaxBatchL = 17'(MAX_BATCH);

  // The side data waits in a delay line while the divider works. Stage 1 feeds the
  // divider, stages 2 and 3 build the destination index, and the delay line makes
  // up the rest of the divider depth.
  localparam int DlyLen = DivNumW - 2;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indices are dropped.
  // ---------------------------------------------------------------------------
  logic [ChanRegW-1:0] channels;
  logic [DimRegW-1:0]  src_height;
  logic [DimRegW-1:0]  src_width;
  logic [DimRegW-1:0]  dst_height;
  logic [DimRegW-1:0]  dst_width;
  logic [ModeW-1:0]    mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels   <= RST_CHANNELS;
      src_height <= RST_SRC_HEIGHT;
      src_width  <= RST_SRC_WIDTH;
      dst_height <= RST_DST_HEIGHT;
      dst_width  <= RST_DST_WIDTH;
      mode       <= RST_MODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHANNELS:   channels   <= cfg_data[ChanRegW-1:0];
        CFG_SRC_HEIGHT: src_height <= cfg_data[DimRegW-1:0];
        CFG_SRC_WIDTH:  src_width  <= cfg_data[DimRegW-1:0];
        CFG_DST_HEIGHT: dst_height <= cfg_data[DimRegW-1:0];
        CFG_DST_WIDTH:  dst_width  <= cfg_data[DimRegW-1:0];
        CFG_MODE:       mode       <= cfg_data[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input buffer: two entries, so in_ready comes straight from a register and does
  // not follow out_ready through the pipeline.
  // ---------------------------------------------------------------------------
  in_item_t   buf_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] buf_cnt;
  logic       push;
  logic       pop;
  logic       en;
  in_item_t   head;

  // The whole pipeline moves when the output register is free or being drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = (buf_cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = en && (buf_cnt != 2'd0);
  assign head     = buf_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= '{batch: batch, channel: channel, out_row: out_row,
                           out_col: out_col};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      buf_cnt <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      buf_cnt <= buf_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: crop geometry, scaling numerators, plane number and range checks.
  // The crop is half the source size, centered; its inclusive span is one more.
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]    crop_h;
  logic [PosW-1:0]    crop_w;
  logic [DimRegW-1:0] rem_h;
  logic [DimRegW-1:0] rem_w;
  logic [DimRegW-1:0] span_h;
  logic [DimRegW-1:0] span_w;
  logic [20:0]        prod_r;
  logic [20:0]        prod_c;
  logic [PlaneW-1:0]  plane_w;
  logic               cfg_ok;
  logic               pos_ok;

  assign crop_h = src_height[DimRegW-1:1];
  assign crop_w = src_width[DimRegW-1:1];
  assign rem_h  = src_height - {1'b0, crop_h};
  assign rem_w  = src_width - {1'b0, crop_w};
  assign span_h = {1'b0, crop_h} + DimRegW'(1);
  assign span_w = {1'b0, crop_w} + DimRegW'(1);
  assign prod_r = 21'(head.out_row) * 21'(span_h);
  assign prod_c = 21'(head.out_col) * 21'(span_w);
  assign plane_w = PlaneW'(head.batch) * PlaneW'(channels) + PlaneW'(head.channel);

  assign cfg_ok = (mode == MODE_NEAREST)
               && (channels != '0) && (13'(channels) <= MaxChanL)
               && (src_height != '0) && (14'(src_height) <= MaxDimL)
               && (src_width != '0) && (14'(src_width) <= MaxDimL)
               && (dst_height != '0) && (14'(dst_height) <= MaxDimL)
               && (dst_width != '0) && (14'(dst_width) <= MaxDimL);

  assign pos_ok = (ChanRegW'(head.channel) < channels)
               && (DimRegW'(head.out_row) < dst_height)
               && (DimRegW'(head.out_col) < dst_width)
               && (17'(head.batch) < MaxBatchL);

  logic                s1_v;
  logic [DivNumW-1:0]  s1_num_r;
  logic [DivNumW-1:0]  s1_num_c;
  logic [PlaneW-1:0]   s1_plane;
  logic [PosW-1:0]     s1_oy;
  logic [PosW-1:0]     s1_ox;
  logic [PosW-1:0]     s1_row;
  logic [PosW-1:0]     s1_col;
  logic                s1_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= (buf_cnt != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_num_r <= prod_r[DivNumW-1:0];
      s1_num_c <= prod_c[DivNumW-1:0];
      s1_plane <= plane_w;
      s1_oy    <= rem_h[DimRegW-1:1];
      s1_ox    <= rem_w[DimRegW-1:1];
      s1_row   <= head.out_row;
      s1_col   <= head.out_col;
      s1_ok    <= cfg_ok && pos_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Row and column scaling: position * span / destination size.
  // ---------------------------------------------------------------------------
  logic [DivNumW-1:0] quo_r;
  logic [DivNumW-1:0] quo_c;

  ncr_div #(.NUM_W(DivNumW), .DEN_W(DimRegW)) u_div_row (
    .clk (clk),
    .en  (en),
    .num (s1_num_r),
    .den (dst_height),
    .quo (quo_r)
  );

  ncr_div #(.NUM_W(DivNumW), .DEN_W(DimRegW)) u_div_col (
    .clk (clk),
    .en  (en),
    .num (s1_num_c),
    .den (dst_width),
    .quo (quo_c)
  );

  // ---------------------------------------------------------------------------
  // Stages 2 and 3: source plane base and destination index, beside the divider.
  // ---------------------------------------------------------------------------
  logic                s2_v;
  logic [RowAccW-1:0]  s2_ps;
  logic [RowAccW-1:0]  s2_dp;
  logic [PosW-1:0]     s2_col;
  logic [PosW-1:0]     s2_oy;
  logic [PosW-1:0]     s2_ox;
  logic                s2_ok;

  logic                s3_v;
  logic [RowAccW-1:0]  s3_ps;
  logic [IndexW-1:0]   s3_dst;
  logic [PosW-1:0]     s3_oy;
  logic [PosW-1:0]     s3_ox;
  logic                s3_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ps  <= RowAccW'(s1_plane) * RowAccW'(src_height);
      s2_dp  <= RowAccW'(s1_plane) * RowAccW'(dst_height) + RowAccW'(s1_row);
      s2_col <= s1_col;
      s2_oy  <= s1_oy;
      s2_ox  <= s1_ox;
      s2_ok  <= s1_ok;

      // Only the low 32 bits matter, so the product simply wraps.
      s3_ps  <= s2_ps;
      s3_dst <= IndexW'(s2_dp) * IndexW'(dst_width) + IndexW'(s2_col);
      s3_oy  <= s2_oy;
      s3_ox  <= s2_ox;
      s3_ok  <= s2_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Delay line that keeps the side data in step with the divider output.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [RowAccW-1:0] ps;
    logic [IndexW-1:0]  dst;
    logic [PosW-1:0]    oy;
    logic [PosW-1:0]    ox;
    logic               ok;
  } side_t;

  side_t             dly     [DlyLen];
  logic [DlyLen-1:0] dly_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_v <= '0;
    end else if (en) begin
      dly_v <= {dly_v[DlyLen-2:0], s3_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= '{ps: s3_ps, dst: s3_dst, oy: s3_oy, ox: s3_ox, ok: s3_ok};
      for (int i = 1; i < DlyLen; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 22: add crop offsets to source row and column; row goes onto the plane base.
  // ---------------------------------------------------------------------------
  logic                s22_v;
  logic [SrcAccW-1:0]  s22_row_acc;
  logic [DivNumW:0]    s22_sc;
  logic [IndexW-1:0]   s22_dst;
  logic                s22_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s22_v <= 1'b0;
    end else if (en) begin
      s22_v <= dly_v[DlyLen-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s22_row_acc <= SrcAccW'(dly[DlyLen-1].ps) + SrcAccW'(quo_r)
                   + SrcAccW'(dly[DlyLen-1].oy);
      s22_sc      <= (DivNumW + 1)'(quo_c) + (DivNumW + 1)'(dly[DlyLen-1].ox);
      s22_dst     <= dly[DlyLen-1].dst;
      s22_ok      <= dly[DlyLen-1].ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: source index and the wrap to the index width.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s22_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src_index <= (IndexW'(s22_row_acc) * IndexW'(src_width) + IndexW'(s22_sc))
                 & IdxMask;
      dst_index <= s22_dst & IdxMask;
      mode_ok   <= s22_ok;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ncr_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// A zero divisor gives a zero quotient.
module ncr_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] n_q [NUM_W];
  logic [NUM_W-1:0] q_q [NUM_W];
  logic [DEN_W-1:0] r_q [NUM_W];
  logic [DEN_W-1:0] d_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] n_in;
    logic [NUM_W-1:0] q_in;
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign n_in = num;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_rest
      assign n_in = n_q[k-1];
      assign q_in = q_q[k-1];
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
    end

    assign trial = {r_in, n_in[NUM_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k] <= {n_in[NUM_W-2:0], 1'b0};
        q_q[k] <= {q_in[NUM_W-2:0], ge};
        r_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        d_q[k] <= d_in;
      end
    end
  end

  // The last stage's shifted numerator is spent; only quotient and divisor leave.
  assign quo = (d_q[NUM_W-1] == '0) ? '0 : q_q[NUM_W-1];

endmodule

`default_nettype wire
